[rtl/che_pkg.sv]
// shared constants for the class histogram entropy unit
package che_pkg;

  localparam int LABEL_W = 6;
  localparam int CFG_W   = 7;
  localparam int ENT_W   = 19;
  localparam int TOTAL_W = 16;
  localparam int FRAC_W  = 16;

  localparam logic [CFG_W-1:0]   CFG_RESET = 7'd2;
  localparam logic [ENT_W-1:0]   ENT_MAX   = {ENT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

[rtl/class_histogram_entropy_unit.sv]
// top level: class histogram with base-2 shannon entropy on the last sample
//
// Labels are counted into a histogram memory of NUM_CLASSES entries; each
// counting transfer reads the count, then writes back the incremented count,
// and a transfer with a label at or above num_classes is not counted but
// flags the error. After the last sample the unit walks the histogram
// once, one class at a time, clearing each entry as it goes. A shared log unit
// gives log2 of the total and of each nonzero count by normalizing one bit at
// a time and then squaring once per fraction bit, with LW = max(W,32) bits of
// normalization and W = COUNT_BITS + clog2(NUM_CLASSES). Each nonzero class
// also takes a read, a check, a multiply and an accumulate step, each empty
// class a read and a check, and a restoring divider gives one quotient bit per
// cycle (QW = W + log width + 1 bits). An empty node skips the walk. After
// reset the memory is cleared one entry at a time before the first label
// transfer is taken. The result sits in an output register, so label
// transfers resume while it waits to be taken.
module class_histogram_entropy_unit #(
  parameter int NUM_CLASSES = 64,
  parameter int COUNT_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [che_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [che_pkg::LABEL_W-1:0]   class_label_i,
  input  logic                          last_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [che_pkg::ENT_W-1:0]     entropy_q16_o,
  output logic [che_pkg::TOTAL_W-1:0]   sample_total_o,
  output logic                          label_error_o
);

  localparam int IW  = (NUM_CLASSES > 2) ? $clog2(NUM_CLASSES) : 1;
  localparam int LXW = (IW > che_pkg::LABEL_W) ? IW : che_pkg::LABEL_W;
  localparam int SW  = COUNT_BITS + IW;               // exact sum of all counts
  localparam int LW  = (SW > 32) ? SW : 32;
  localparam int LGW = $clog2(LW) + che_pkg::FRAC_W;  // log result width
  localparam int AW  = SW + LGW;                      // accumulator width
  localparam int QW  = AW + 1;                        // dividend and quotient

  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  // sequencer states
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_INC  = 4'd2;
  localparam logic [3:0] S_LTS  = 4'd3;
  localparam logic [3:0] S_LT   = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_RDW  = 4'd6;
  localparam logic [3:0] S_LC   = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_ACC  = 4'd9;
  localparam logic [3:0] S_DIVS = 4'd10;
  localparam logic [3:0] S_DIV  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  logic [3:0]                   state_q;
  logic [che_pkg::CFG_W-1:0]    ncls_q;
  logic [IW-1:0]                idx_q;
  logic                         last_q;
  logic [SW-1:0]                sum_q;
  logic [che_pkg::TOTAL_W-1:0]  total_q;
  logic                         err_q;
  logic [LGW-1:0]               lt_q;
  logic [LGW-1:0]               diff_q;
  logic [COUNT_BITS-1:0]        c_q;
  logic [COUNT_BITS+LGW-1:0]    prod_q;
  logic [AW-1:0]                acc_q;
  logic [che_pkg::ENT_W-1:0]    ent_q;

  logic                         out_valid_q;
  logic [che_pkg::ENT_W-1:0]    out_ent_q;
  logic [che_pkg::TOTAL_W-1:0]  out_total_q;
  logic                         out_err_q;

  // histogram memory
  logic [COUNT_BITS-1:0]        hist_mem [NUM_CLASSES];
  logic [COUNT_BITS-1:0]        rd_q;
  logic [IW-1:0]                rd_addr;
  logic                         wr_en;
  logic [COUNT_BITS-1:0]        wr_data;

  logic                         in_xfer;
  logic [LXW-1:0]               label_x;
  logic [IW-1:0]                label_idx;
  logic                         label_ok;
  logic                         walk_end;
  logic                         out_free;

  logic                         lg_start;
  logic [SW-1:0]                lg_x;
  logic                         lg_done;
  logic [LGW-1:0]               lg_res;

  logic                         div_start;
  logic [QW-1:0]                div_num;
  logic                         div_done;
  logic [QW-1:0]                div_quo;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign label_x   = LXW'(class_label_i);
  assign label_idx = label_x[IW-1:0];
  assign label_ok  = ({1'b0, class_label_i} < ncls_q) &&
                     (32'(class_label_i) < 32'(NUM_CLASSES));
  assign walk_end  = (idx_q == IW'(NUM_CLASSES - 1));
  assign out_free  = !out_valid_q || !out_stall_i;

  // memory port control
  always_comb begin
    rd_addr = idx_q;
    wr_en   = 1'b0;
    wr_data = '0;
    case (state_q)
      S_IDLE: rd_addr = label_idx;
      S_CLR:  wr_en   = 1'b1;
      S_INC: begin
        wr_en   = (rd_q != CMAX);
        wr_data = rd_q + 1'b1;
      end
      S_RDW:  wr_en   = 1'b1;  // clear each entry as the walk passes it
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[idx_q] <= wr_data;
    end
    rd_q <= hist_mem[rd_addr];
  end

  // shared log unit: total first, then each nonzero count
  // an empty node never starts it, log of zero would not normalize
  assign lg_start = (state_q == S_LTS && sum_q != '0) || (state_q == S_RDW && rd_q != '0);
  assign lg_x     = (state_q == S_LTS) ? sum_q : SW'(rd_q);

  che_log2 #(.XW(SW)) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lg_start),
    .x_i     (lg_x),
    .done_o  (lg_done),
    .lg_o    (lg_res)
  );

  // round half up: (acc + T/2) / T
  assign div_start = (state_q == S_DIVS);
  assign div_num   = QW'(acc_q) + QW'(sum_q >> 1);

  che_div #(.NW(QW), .DW(SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      ncls_q      <= che_pkg::CFG_RESET;
      idx_q       <= '0;
      last_q      <= 1'b0;
      sum_q       <= '0;
      total_q     <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ncls_q <= cfg_data_i;
      end
      // output register: refilled from S_OUT, emptied when taken
      if (out_free) begin
        out_valid_q <= (state_q == S_OUT);
      end
      case (state_q)
        S_CLR: begin
          if (walk_end) begin
            idx_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            idx_q  <= label_idx;
            last_q <= last_sample_i;
            if (label_ok) begin
              state_q <= S_INC;
            end else begin
              err_q <= 1'b1;
              if (last_sample_i) begin
                state_q <= S_LTS;
              end
            end
          end
        end
        S_INC: begin
          if (rd_q != CMAX) begin
            sum_q <= sum_q + 1'b1;
          end
          if (total_q != che_pkg::TOTAL_MAX) begin
            total_q <= total_q + 1'b1;
          end
          state_q <= last_q ? S_LTS : S_IDLE;
        end
        S_LTS: begin
          idx_q <= '0;
          // empty node: histogram is already all zero
          state_q <= (sum_q == '0) ? S_OUT : S_LT;
        end
        S_LT: begin
          if (lg_done) begin
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_RDW;
        S_RDW: begin
          if (rd_q != '0) begin
            state_q <= S_LC;
          end else if (walk_end) begin
            state_q <= S_DIVS;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_LC: begin
          if (lg_done) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          if (walk_end) begin
            state_q <= S_DIVS;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_DIVS: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            sum_q       <= '0;
            total_q     <= '0;
            err_q       <= 1'b0;
            idx_q       <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_LTS: begin
        acc_q <= '0;
        ent_q <= '0;
      end
      S_LT: begin
        if (lg_done) begin
          lt_q <= lg_res;
        end
      end
      S_RDW: c_q <= rd_q;
      S_LC: begin
        if (lg_done) begin
          diff_q <= (lt_q > lg_res) ? (lt_q - lg_res) : '0;
        end
      end
      S_MUL: prod_q <= (COUNT_BITS+LGW)'(c_q) * (COUNT_BITS+LGW)'(diff_q);
      S_ACC: acc_q  <= acc_q + AW'(prod_q);
      S_DIV: begin
        if (div_done) begin
          ent_q <= (div_quo > QW'(che_pkg::ENT_MAX)) ? che_pkg::ENT_MAX
                                                     : div_quo[che_pkg::ENT_W-1:0];
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_ent_q   <= ent_q;
          out_total_q <= total_q;
          out_err_q   <= err_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign entropy_q16_o  = out_ent_q;
  assign sample_total_o = out_total_q;
  assign label_error_o  = out_err_q;

  // a node with no counted samples has zero entropy
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sample_total_o == '0) |-> (entropy_q16_o == '0))
    else $error("nonzero entropy for empty node");

  // the exact sum and the saturating total are zero together
  a_sum_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q == '0) |-> (sum_q == '0))
    else $error("sum and total disagree");

  // log results only arrive while the sequencer waits for them
  a_log_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lg_done |-> (state_q == S_LT || state_q == S_LC))
    else $error("unexpected log result");

  // divider results only arrive in the divide state
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("unexpected quotient");

endmodule

[rtl/che_log2.sv]
// iterative base-2 log in q16: normalize one bit a cycle, then one squaring a cycle
module che_log2 #(
  parameter int XW = 16,
  parameter int LW = (XW > 32) ? XW : 32,
  parameter int RW = $clog2(LW) + che_pkg::FRAC_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [XW-1:0] x_i,
  output logic          done_o,
  output logic [RW-1:0] lg_o
);

  localparam int NW = $clog2(LW);
  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_SQ   = 2'd2;

  logic [1:0]                  state_q;
  logic [LW-1:0]               norm_q;
  logic [NW-1:0]               sh_q;
  logic [31:0]                 m_q;
  logic [3:0]                  cnt_q;
  logic [che_pkg::FRAC_W-1:0]  frac_q;
  logic                        done_q;
  logic [63:0]                 sq;
  logic [32:0]                 sq_s;
  logic [NW-1:0]               n_val;

  assign sq    = 64'(m_q) * 64'(m_q);
  assign sq_s  = sq[63:31];
  assign n_val = NW'(LW - 1) - sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == L_SQ) && (cnt_q == 4'd15);
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            state_q <= L_NORM;
          end
        end
        L_NORM: begin
          if (norm_q[LW-1]) begin
            state_q <= L_SQ;
          end
        end
        L_SQ: begin
          if (cnt_q == 4'd15) begin
            state_q <= L_IDLE;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        norm_q <= LW'(x_i);
        sh_q   <= '0;
        cnt_q  <= '0;
        frac_q <= '0;
      end
      L_NORM: begin
        if (norm_q[LW-1]) begin
          m_q <= norm_q[LW-1 -: 32];
        end else begin
          norm_q <= norm_q << 1;
          sh_q   <= sh_q + 1'b1;
        end
      end
      L_SQ: begin
        cnt_q <= cnt_q + 1'b1;
        if (sq_s[32]) begin
          m_q    <= sq_s[32:1];
          frac_q <= {frac_q[che_pkg::FRAC_W-2:0], 1'b1};
        end else begin
          m_q    <= sq_s[31:0];
          frac_q <= {frac_q[che_pkg::FRAC_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign lg_o   = {n_val, frac_q};

endmodule

[rtl/che_div.sv]
// restoring divider, one quotient bit per cycle
module che_div #(
  parameter int NW = 40,
  parameter int DW = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] q_q;
  logic [DW:0]   rem_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_q[DW-1:0], q_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(NW - 1));
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      q_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      q_q   <= {q_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule
